// ===== rtl/sorted_priority_queue_top_assert.svh =====
// Assertion macros for the sorted priority queue top level.
// Needs a clock and an active-low reset name at each use; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types, widths and codes of the sorted priority queue.
// No dependencies; compile first.
`default_nettype none

package spq_pkg;

    localparam int SPQ_CAPACITY_DEF = 16;
    localparam int PRIO_W           = 16;
    localparam int VAL_W            = 32;
    localparam int CNT_W            = 5;
    localparam int STAT_W           = 2;
    localparam int LIMIT_RESET      = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_REMOVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]  val;
    } t_entry;

    typedef struct packed {
        logic              operation;
        logic [PRIO_W-1:0] priority_req;
        logic [VAL_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [PRIO_W-1:0] out_priority;
        logic [VAL_W-1:0]  out_value;
        logic [CNT_W-1:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on spq_pkg for the field widths.
`default_nettype none

interface spq_in_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [PRIO_W-1:0] priority_req;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output operation, output priority_req, output value,
                    input ready);
    modport sink   (input valid, input operation, input priority_req, input value,
                    output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] out_priority;
    logic [VAL_W-1:0]  out_value;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, output status, output out_priority, output out_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input out_priority, input out_value,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue: top level with limit register, output register and assertions.
// Depends on spq_pkg, spq_if, spq_store, spq_seq and the assertion macro header.
`default_nettype none

// Priority queue of CAPACITY entries kept sorted in a circular buffer; larger
// priority leaves first, equal priorities leave in arrival order. One request is
// taken at a time. An insert moves past the lower-priority entries behind its
// place, at most the count held before it (up to 15 at the default capacity):
// the insertion walk compares one stored neighbor per cycle through the single
// read port of the entry memory. A remove reads the head slot, and a refused
// request goes straight to its result. A finished result waits in the output
// register, so the next request can be taken while it is pending. Entry memory
// is not cleared at reset; only written slots are read. The limit register
// bounds the count: 0 acts as 1, values above CAPACITY act as CAPACITY; write it
// only while no request is in progress.
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    spq_in_if.sink                         i_in,
    spq_out_if.source                      o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [spq_pkg::CNT_W-1:0] i_cfg_wdata
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [CNT_W-1:0] r_cfg_limit;
    logic [CNT_W-1:0] w_eff_limit;
    t_req             w_req;
    logic             w_in_ready;
    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;
    logic             r_out_valid;
    t_result          r_out;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    t_entry           w_wr_entry;
    logic [AW-1:0]    w_rd_addr;
    t_entry           w_rd_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= CNT_W'(LIMIT_RESET);
        end else if (i_cfg_we) begin
            r_cfg_limit <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_eff_limit = (r_cfg_limit == '0) ? CNT_W'(1) : r_cfg_limit;
        if (32'(w_eff_limit) > CAPACITY) begin
            w_eff_limit = CNT_W'(CAPACITY);
        end
    end

    assign w_req.operation    = i_in.operation;
    assign w_req.priority_req = i_in.priority_req;
    assign w_req.value        = i_in.value;
    assign i_in.ready         = w_in_ready;

    spq_seq #(.CAPACITY(CAPACITY)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_req       (w_req),
        .i_eff_limit (w_eff_limit),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_entry  (w_wr_entry),
        .o_rd_addr   (w_rd_addr),
        .i_rd_entry  (w_rd_entry)
    );

    spq_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_entry (w_wr_entry),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_rd_entry)
    );

    // Load a new result when the output register is empty or drains this cycle.
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.out_priority = r_out.out_priority;
    assign o_out.out_value    = r_out.out_value;
    assign o_out.entry_count  = r_out.entry_count;

`include "sorted_priority_queue_top_assert.svh"

    `SPQ_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "request taken while a request is in progress")
    `SPQ_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_res_valid && w_res_ready,
        o_out.valid && (o_out.entry_count == $past(w_res.entry_count)),
        "result lost on the way to the output register")
    `SPQ_ASSERT_IMP(a_empty_refusal, i_clk, i_rst_n,
        w_res_valid && (w_res.status == STAT_EMPTY),
        (w_res.entry_count == '0) && (w_res.out_priority == '0) && (w_res.out_value == '0),
        "empty refusal with nonzero count or entry")

endmodule

`default_nettype wire

// ===== rtl/spq_store.sv =====
// Entry memory of the queue: one write port, one registered read port.
// Depends on spq_pkg for the entry type.
`default_nettype none

module spq_store #(
    parameter int  CAPACITY = spq_pkg::SPQ_CAPACITY_DEF,
    localparam int AW       = $clog2(CAPACITY)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire spq_pkg::t_entry i_wr_entry,
    input  wire logic [AW-1:0]   i_rd_addr,
    output spq_pkg::t_entry      o_rd_entry
);
    import spq_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd;

endmodule

`default_nettype wire

// ===== rtl/spq_seq.sv =====
// Sequencer of the queue: head/count pointers and the insertion walk that
// compares one stored neighbor per cycle. Depends on spq_pkg and drives spq_store.
`default_nettype none

module spq_seq #(
    parameter int  CAPACITY = spq_pkg::SPQ_CAPACITY_DEF,
    localparam int AW       = $clog2(CAPACITY)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire spq_pkg::t_req            i_req,
    input  wire logic [spq_pkg::CNT_W-1:0] i_eff_limit,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output spq_pkg::t_result              o_res,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output spq_pkg::t_entry               o_wr_entry,
    output logic [AW-1:0]                 o_rd_addr,
    input  wire spq_pkg::t_entry          i_rd_entry
);
    import spq_pkg::*;

    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        if (a == '0) begin
            return AW'(CAPACITY - 1);
        end
        return a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        if (a == AW'(CAPACITY - 1)) begin
            return '0;
        end
        return a + 1'b1;
    endfunction

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_prev, n_prev;
    logic [CNT_W-1:0] r_steps, n_steps;
    t_entry           r_mov, n_mov;
    t_result          r_res, n_res;

    logic             w_accept;
    logic             w_full;
    logic             w_move;
    logic [SW-1:0]    w_sum;
    logic [AW-1:0]    w_tail;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_full   = (r_count >= i_eff_limit);
    assign w_move   = (r_steps != '0) && (i_rd_entry.prio < r_mov.prio);

    // Tail slot: head + count stays below twice the capacity, so one subtract wraps it.
    always_comb begin
        w_sum = SW'(r_head) + SW'(r_count);
        if (w_sum >= SW'(CAPACITY)) begin
            w_sum = w_sum - SW'(CAPACITY);
        end
        w_tail = w_sum[AW-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.operation == OP_REMOVE) begin
                        n_state = (r_count == '0) ? ST_DONE : ST_REMOVE;
                    end else begin
                        n_state = w_full ? ST_DONE : ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!w_move) begin
                    n_state = ST_DONE;
                end
            end
            ST_REMOVE: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_pos      = r_pos;
        n_prev     = r_prev;
        n_steps    = r_steps;
        n_mov      = r_mov;
        n_res      = r_res;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_pos;
        o_wr_entry = r_mov;
        o_rd_addr  = r_prev;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.operation == OP_REMOVE) begin
                        o_rd_addr = r_head;
                        if (r_count == '0) begin
                            n_res = '{STAT_EMPTY, '0, '0, r_count};
                        end
                    end else if (w_full) begin
                        n_res = '{STAT_FULL, '0, '0, r_count};
                    end else begin
                        // Hold the new entry aside and fetch its older neighbor.
                        n_pos      = w_tail;
                        n_prev     = f_dec(w_tail);
                        o_rd_addr  = f_dec(w_tail);
                        n_steps    = r_count;
                        n_count    = r_count + 1'b1;
                        n_mov.prio = i_req.priority_req;
                        n_mov.val  = i_req.value;
                    end
                end
            end
            ST_WALK: begin
                o_wr_en = 1'b1;
                if (w_move) begin
                    // Shift the lower-priority neighbor back and advance toward the head.
                    o_wr_entry = i_rd_entry;
                    n_pos      = r_prev;
                    n_prev     = f_dec(r_prev);
                    o_rd_addr  = f_dec(r_prev);
                    n_steps    = r_steps - 1'b1;
                end else begin
                    o_wr_entry = r_mov;
                    n_res      = '{STAT_DONE, '0, '0, r_count};
                end
            end
            ST_REMOVE: begin
                n_head  = f_inc(r_head);
                n_count = r_count - 1'b1;
                n_res   = '{STAT_DONE, i_rd_entry.prio, i_rd_entry.val, r_count - 1'b1};
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_mov   <= n_mov;
        r_res   <= n_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire
